// ===== sv/lps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

    localparam int MAX_LIMIT  = 1024;
    localparam int MAX_PRIMES = 256;

    localparam int LIMIT_W    = 11;
    localparam int COUNT_W    = 9;
    localparam int INDEX_W    = 8;
    localparam int PROD_W     = 2 * LIMIT_W;

    localparam int MARK_DEPTH = MAX_LIMIT + 1;
    localparam int MARK_AW    = $clog2(MARK_DEPTH);
    localparam int PLIST_AW   = $clog2(MAX_PRIMES);

    typedef enum logic [0:0] {
        OP_BUILD = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                opcode;
        logic [LIMIT_W-1:0] upper_limit;
        logic [INDEX_W-1:0] prime_index;
    } lps_req_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] prime_value;
        logic [COUNT_W-1:0] prime_count;
        logic               index_valid;
    } lps_rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_WALK_RD,
        S_WALK_TEST,
        S_LIST_RD,
        S_MARK
    } lps_state_t;

endpackage

`default_nettype wire

// ===== sv/linear_prime_sieve.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Linear (Euler) prime sieve with a readable prime list.
// Command channel: an item (req) is taken when start is high and busy is low.
// Result channel: done pulses for one cycle with rsp; there is no backpressure,
// the receiver must take the beat in that cycle.
// Read (OP_READ): the prime-list memory read is registered at the accepting
// edge, and done and rsp are registered from it in S_RD_WAIT.
// Build (OP_BUILD): the walk takes each number 2..bound through a mark read
// (S_WALK_RD), a test and clear (S_WALK_TEST) and a prime-list read
// (S_LIST_RD), then an S_MARK step for each listed prime tried (each mark,
// and the try whose product passes the bound).
// The mark memory holds the smallest prime factor of each marked number;
// the walk clears each entry after testing it, so the memory is all zero
// between builds and a build needs no clearing pass of its own.
// Reset: the prime count goes to zero, and a pass over all 1025 entries
// clears the mark memory; busy stays high until it ends.
// busy is low in the cycle done is shown, so a new item may be taken then.

module linear_prime_sieve (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire lps_pkg::lps_req_t req,
    output logic                  done,
    output lps_pkg::lps_rsp_t     rsp
);

    import lps_pkg::*;

    logic [LIMIT_W-1:0] mark_mem [MARK_DEPTH];
    logic [LIMIT_W-1:0] plist_mem [MAX_PRIMES];

    lps_state_t state_reg, state_next;

    logic [MARK_AW-1:0]  clr_reg, clr_next;
    logic [LIMIT_W-1:0]  bound_reg, bound_next;
    logic [LIMIT_W-1:0]  i_reg, i_next;
    logic [LIMIT_W-1:0]  lp_reg, lp_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  j_reg, j_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    logic                done_reg, done_next;
    lps_rsp_t            rsp_reg, rsp_next;

    logic                mark_we;
    logic [MARK_AW-1:0]  mark_waddr;
    logic [LIMIT_W-1:0]  mark_wdata;
    logic [MARK_AW-1:0]  mark_raddr;
    logic [LIMIT_W-1:0]  mark_rdata;

    logic                plist_we;
    logic [PLIST_AW-1:0] plist_waddr;
    logic [LIMIT_W-1:0]  plist_wdata;
    logic [PLIST_AW-1:0] plist_raddr;
    logic [LIMIT_W-1:0]  plist_rdata;

    logic                accept;
    logic [PROD_W-1:0]   prod;
    logic [COUNT_W-1:0]  j_inc;
    logic                prod_over;
    logic                list_end;
    logic                is_new_prime;

    assign accept       = start && (state_reg == S_IDLE);
    assign prod         = PROD_W'(i_reg) * PROD_W'(plist_rdata);
    assign prod_over    = prod > PROD_W'(bound_reg);
    assign j_inc        = j_reg + COUNT_W'(1);
    assign list_end     = (plist_rdata == lp_reg) || (j_inc == count_reg);
    assign is_new_prime = (mark_rdata == '0) && (count_reg < COUNT_W'(MAX_PRIMES));

    // ---- memories ----
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rdata <= mark_mem[mark_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (plist_we)
        begin
            plist_mem[plist_waddr] <= plist_wdata;
        end
        plist_rdata <= plist_mem[plist_raddr];
    end

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == MARK_AW'(MARK_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.opcode == OP_READ) ? S_RD_WAIT : S_WALK_RD;
                end
            end
            S_RD_WAIT:
            begin
                state_next = S_IDLE;
            end
            S_WALK_RD:
            begin
                state_next = (i_reg > bound_reg) ? S_IDLE : S_WALK_TEST;
            end
            S_WALK_TEST:
            begin
                if (is_new_prime || count_reg != '0)
                begin
                    state_next = S_LIST_RD;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_LIST_RD:
            begin
                state_next = S_MARK;
            end
            S_MARK:
            begin
                if (prod_over || list_end)
                begin
                    state_next = S_WALK_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---- datapath and outputs ----
    always_comb
    begin
        clr_next    = clr_reg;
        bound_next  = bound_reg;
        i_next      = i_reg;
        lp_next     = lp_reg;
        count_next  = count_reg;
        j_next      = j_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;

        mark_we     = 1'b0;
        mark_waddr  = i_reg[MARK_AW-1:0];
        mark_wdata  = '0;
        mark_raddr  = i_reg[MARK_AW-1:0];
        plist_we    = 1'b0;
        plist_waddr = count_reg[PLIST_AW-1:0];
        plist_wdata = i_reg;
        plist_raddr = j_reg[PLIST_AW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                mark_we    = 1'b1;
                mark_waddr = clr_reg;
                clr_next   = clr_reg + MARK_AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == OP_READ)
                    begin
                        plist_raddr = PLIST_AW'(req.prime_index);
                        idx_next    = req.prime_index;
                    end
                    else
                    begin
                        bound_next = (req.upper_limit > LIMIT_W'(MAX_LIMIT))
                                     ? LIMIT_W'(MAX_LIMIT) : req.upper_limit;
                        i_next     = LIMIT_W'(2);
                        count_next = '0;
                    end
                end
            end
            S_RD_WAIT:
            begin
                done_next = 1'b1;
                rsp_next.prime_count = count_reg;
                if (COUNT_W'(idx_reg) < count_reg)
                begin
                    rsp_next.index_valid = 1'b1;
                    rsp_next.prime_value = plist_rdata;
                end
                else
                begin
                    rsp_next.index_valid = 1'b0;
                    rsp_next.prime_value = '0;
                end
            end
            S_WALK_RD:
            begin
                if (i_reg > bound_reg)
                begin
                    done_next            = 1'b1;
                    rsp_next.prime_value = '0;
                    rsp_next.prime_count = count_reg;
                    rsp_next.index_valid = 1'b0;
                end
            end
            S_WALK_TEST:
            begin
                // clear behind the walk so the map is zero for the next build
                mark_we = 1'b1;
                lp_next = (mark_rdata == '0) ? i_reg : mark_rdata;
                j_next  = '0;
                if (is_new_prime)
                begin
                    plist_we   = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                end
                else if (count_reg == '0)
                begin
                    i_next = i_reg + LIMIT_W'(1);
                end
            end
            S_LIST_RD:
            begin
                plist_raddr = j_reg[PLIST_AW-1:0];
            end
            S_MARK:
            begin
                // prefetch the next listed prime; harmless when the loop ends
                plist_raddr = j_inc[PLIST_AW-1:0];
                if (prod_over)
                begin
                    i_next = i_reg + LIMIT_W'(1);
                end
                else
                begin
                    mark_we    = 1'b1;
                    mark_waddr = prod[MARK_AW-1:0];
                    mark_wdata = plist_rdata;
                    if (list_end)
                    begin
                        i_next = i_reg + LIMIT_W'(1);
                    end
                    else
                    begin
                        j_next = j_inc;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg <= bound_next;
        i_reg     <= i_next;
        lp_reg    <= lp_next;
        j_reg     <= j_next;
        idx_reg   <= idx_next;
        rsp_reg   <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// ===== sv/lps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lps_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire lps_pkg::lps_req_t req,
    input wire logic              done,
    input wire lps_pkg::lps_rsp_t rsp
);

    import lps_pkg::*;

    logic unused_req;
    assign unused_req = ^req;

    // a taken command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy next cycle");

    // beats never come back to back (the design gives one beat per command)
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    a_valid_is_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.index_valid) |-> (rsp.prime_value >= LIMIT_W'(2)))
        else $error("valid read returned a value below two");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.index_valid) |-> (rsp.prime_value == '0))
        else $error("invalid result carries a nonzero value");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.prime_count <= COUNT_W'(MAX_PRIMES)))
        else $error("prime count beyond list capacity");

endmodule

bind linear_prime_sieve lps_checker u_lps_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire
